/* design/srcp_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and pipeline depths for the segment rotate/clip/project block.
// No dependencies; all other design files import this package.
package srcp_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int TRIG_FRAC_BITS = 14;
   localparam int COORD_W        = 32;
   localparam int TRIG_W         = 16;
   localparam int SIZE_W         = 13;
   localparam int PIX_W          = 16;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_WIDTH  = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_HEIGHT = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] CSR_COS_ABOUT_Z   = CSR_ADDR_W'(2);
   localparam logic [CSR_ADDR_W-1:0] CSR_SIN_ABOUT_Z   = CSR_ADDR_W'(3);
   localparam logic [CSR_ADDR_W-1:0] CSR_COS_ABOUT_Y   = CSR_ADDR_W'(4);
   localparam logic [CSR_ADDR_W-1:0] CSR_SIN_ABOUT_Y   = CSR_ADDR_W'(5);
   localparam logic [CSR_ADDR_W-1:0] CSR_COS_ABOUT_X   = CSR_ADDR_W'(6);
   localparam logic [CSR_ADDR_W-1:0] CSR_SIN_ABOUT_X   = CSR_ADDR_W'(7);

   localparam logic [SIZE_W-1:0]         WIDTH_RST  = SIZE_W'(640);
   localparam logic [SIZE_W-1:0]         HEIGHT_RST = SIZE_W'(480);
   localparam logic signed [TRIG_W-1:0]  TRIG_ONE   = TRIG_W'(1) << TRIG_FRAC_BITS;
   localparam logic signed [COORD_W-1:0] NEAR_ONE   = COORD_W'(1) << FRAC_BITS;

   // pipeline depths
   localparam int ROT_STAGES   = 3;
   localparam int CLIP_Q_BITS  = FRAC_BITS + 1;
   localparam int CLIP_STAGES  = CLIP_Q_BITS + 3;
   localparam int PROJ_Q_BITS  = PIX_W - 1;
   localparam int PROJ_STAGES  = PROJ_Q_BITS + 3;
   localparam int PIPE_DEPTH   = ROT_STAGES + CLIP_STAGES + PROJ_STAGES;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] cos_z;
      logic signed [TRIG_W-1:0] sin_z;
      logic signed [TRIG_W-1:0] cos_y;
      logic signed [TRIG_W-1:0] sin_y;
      logic signed [TRIG_W-1:0] cos_x;
      logic signed [TRIG_W-1:0] sin_x;
   } trig_type;

endpackage

/* design/srcp_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces: segment request words and projected response words.
// Depends on srcp_pkg.
interface srcp_req_if;
   import srcp_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] start_x;
   logic signed [COORD_W-1:0] start_y;
   logic signed [COORD_W-1:0] start_z;
   logic signed [COORD_W-1:0] end_x;
   logic signed [COORD_W-1:0] end_y;
   logic signed [COORD_W-1:0] end_z;

   modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                   input ready);
   modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                   output ready);
endinterface

interface srcp_rsp_if;
   import srcp_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    visible;
   logic signed [PIX_W-1:0] screen_x0;
   logic signed [PIX_W-1:0] screen_y0;
   logic signed [PIX_W-1:0] screen_x1;
   logic signed [PIX_W-1:0] screen_y1;

   modport source (output valid, visible, screen_x0, screen_y0, screen_x1, screen_y1,
                   input ready);
   modport sink   (input valid, visible, screen_x0, screen_y0, screen_x1, screen_y1,
                   output ready);
endinterface

/* design/srcp_rotator.sv */
`timescale 1ns / 1ps
// Three-stage rotation of one point: about z, then y, then x, Q2.14 trig terms.
// Depends on srcp_pkg.
module srcp_rotator (
   input  logic                clock,
   input  logic                en,
   input  srcp_pkg::point_type pt_in,
   input  srcp_pkg::trig_type  trig,
   output srcp_pkg::point_type pt_out
);
   import srcp_pkg::*;

   localparam int PROD_W = COORD_W + TRIG_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int SH_W   = SUM_W - TRIG_FRAC_BITS;

   // floor shift then saturate to the coordinate range
   function automatic logic signed [COORD_W-1:0] rot_sum(
      input logic signed [PROD_W-1:0] p,
      input logic signed [PROD_W-1:0] q
   );
      logic signed [SUM_W-1:0]   s;
      logic signed [SH_W-1:0]    sh;
      logic signed [COORD_W-1:0] r;
      s  = {p[PROD_W-1], p} + {q[PROD_W-1], q};
      sh = s[SUM_W-1:TRIG_FRAC_BITS];
      if (sh[SH_W-1:COORD_W-1] == {(SH_W-COORD_W+1){sh[SH_W-1]}}) begin
         r = sh[COORD_W-1:0];
      end else if (sh[SH_W-1]) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return r;
   endfunction

   point_type s1_ff, s2_ff, s3_ff;
   point_type s1_in, s2_in, s3_in;

   always_comb begin
      logic signed [PROD_W-1:0] p0, p1, p2, p3;
      // about z
      p0 = PROD_W'(pt_in.x) * PROD_W'(trig.cos_z);
      p1 = PROD_W'(pt_in.y) * PROD_W'(trig.sin_z);
      p2 = PROD_W'(pt_in.x) * PROD_W'(trig.sin_z);
      p3 = PROD_W'(pt_in.y) * PROD_W'(trig.cos_z);
      s1_in.x = rot_sum(p0, -p1);
      s1_in.y = rot_sum(p2, p3);
      s1_in.z = pt_in.z;
   end

   always_comb begin
      logic signed [PROD_W-1:0] p0, p1, p2, p3;
      // about y
      p0 = PROD_W'(s1_ff.x) * PROD_W'(trig.cos_y);
      p1 = PROD_W'(s1_ff.z) * PROD_W'(trig.sin_y);
      p2 = PROD_W'(s1_ff.x) * PROD_W'(trig.sin_y);
      p3 = PROD_W'(s1_ff.z) * PROD_W'(trig.cos_y);
      s2_in.x = rot_sum(p0, p1);
      s2_in.y = s1_ff.y;
      s2_in.z = rot_sum(-p2, p3);
   end

   always_comb begin
      logic signed [PROD_W-1:0] p0, p1, p2, p3;
      // about x
      p0 = PROD_W'(s2_ff.y) * PROD_W'(trig.cos_x);
      p1 = PROD_W'(s2_ff.z) * PROD_W'(trig.sin_x);
      p2 = PROD_W'(s2_ff.y) * PROD_W'(trig.sin_x);
      p3 = PROD_W'(s2_ff.z) * PROD_W'(trig.cos_x);
      s3_in.x = s2_ff.x;
      s3_in.y = rot_sum(p0, -p1);
      s3_in.z = rot_sum(p2, p3);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   assign pt_out = s3_ff;

endmodule

/* design/srcp_project.sv */
`timescale 1ns / 1ps
// Projection of one coordinate: floor(size*(c+z)/(2z)) saturated to 16 bits,
// multiply stage, setup stage, one quotient bit per stage, result stage. Depends on srcp_pkg.
module srcp_project (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [srcp_pkg::COORD_W-1:0] coord,
   input  logic signed [srcp_pkg::COORD_W-1:0] depth,
   input  logic [srcp_pkg::SIZE_W-1:0]         size,
   output logic signed [srcp_pkg::PIX_W-1:0]   pix
);
   import srcp_pkg::*;

   localparam int SUM_W  = COORD_W + 1;
   localparam int N_W    = SIZE_W + 1 + SUM_W;
   localparam int M_W    = N_W - 1;
   localparam int D_W    = COORD_W + 1;
   localparam int Q_BITS = PROJ_Q_BITS;
   localparam int REM_W  = D_W + Q_BITS;

   typedef struct packed {
      logic              neg;
      logic              ovf;
      logic [D_W-1:0]    den;
      logic [REM_W-1:0]  rem;
      logic [Q_BITS-1:0] q;
   } pdiv_type;

   logic signed [N_W-1:0]     num_ff, num_in;
   logic signed [COORD_W-1:0] z_ff;
   pdiv_type                  pd_ff [0:Q_BITS];
   pdiv_type                  pd_in [0:Q_BITS];
   logic signed [PIX_W-1:0]   pix_ff, pix_in;

   always_comb begin
      logic signed [SUM_W-1:0] s;
      s      = {coord[COORD_W-1], coord} + {depth[COORD_W-1], depth};
      num_in = N_W'($signed({1'b0, size})) * N_W'(s);
   end

   // floor for negative n: -floor((-n-1)/d) - 1, i.e. ~n in, ~q out
   always_comb begin
      logic [M_W-1:0] m;
      logic [D_W-1:0] d2;
      m  = num_ff[N_W-1] ? ~num_ff[M_W-1:0] : num_ff[M_W-1:0];
      d2 = {z_ff, 1'b0};
      pd_in[0].neg = num_ff[N_W-1];
      pd_in[0].den = d2;
      pd_in[0].rem = REM_W'(m);
      pd_in[0].ovf = REM_W'(m) >= (REM_W'(d2) << Q_BITS);
      pd_in[0].q   = '0;
   end

   for (genvar i = 0; i < Q_BITS; i++) begin : g_div
      localparam int SH = Q_BITS - 1 - i;
      always_comb begin
         logic [REM_W-1:0] dsh;
         logic             ge;
         dsh          = REM_W'(pd_ff[i].den) << SH;
         ge           = pd_ff[i].rem >= dsh;
         pd_in[i+1]   = pd_ff[i];
         pd_in[i+1].rem = ge ? pd_ff[i].rem - dsh : pd_ff[i].rem;
         pd_in[i+1].q   = pd_ff[i].q | (Q_BITS'(ge) << SH);
      end
   end

   always_comb begin
      logic [PIX_W-1:0] qx;
      qx = {1'b0, pd_ff[Q_BITS].q};
      if (pd_ff[Q_BITS].ovf) begin
         pix_in = pd_ff[Q_BITS].neg ? {1'b1, {(PIX_W-1){1'b0}}} : {1'b0, {(PIX_W-1){1'b1}}};
      end else begin
         pix_in = pd_ff[Q_BITS].neg ? ~qx : qx;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         z_ff   <= depth;
         for (int k = 0; k <= Q_BITS; k++) begin
            pd_ff[k] <= pd_in[k];
         end
         pix_ff <= pix_in;
      end
   end

   assign pix = pix_ff;

endmodule

/* design/segment_rotate_clip_project.sv */
`timescale 1ns / 1ps
// Segment rotate, near-plane clip and perspective projection, top level.
// Depends on srcp_pkg, srcp_if, srcp_rotator and srcp_project.
//
// Usage:
//   req_ch carries one segment word (two Q16.16 endpoints); rsp_ch returns one word per
//   segment: visible flag and two projected pixel positions, zero when not visible.
//   csr_* writes the screen size and the six Q2.14 sines/cosines; write only while idle.
//   Path: 3 rotation, 20 clip and 18 projection stages, then the output register; the first
//   rotation stage loads at the accepting edge.
//   Throughput: one segment per cycle while not frozen; every stage is a register slice
//   sharing one advance enable, the clip interpolation and each projection run one
//   quotient bit per stage.
//   Reset clears all valid bits and loads 640x480 with identity rotation.
//   When the receiver stalls with a word held in the output register, the pipeline
//   keeps advancing until its last stage holds a word, then freezes; nothing is lost
//   or repeated, and req_ch.ready drops only while frozen.
module segment_rotate_clip_project (
   input  logic                              clock,
   input  logic                              reset,
   srcp_req_if.sink                          req_ch,
   srcp_rsp_if.source                        rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [srcp_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [srcp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import srcp_pkg::*;

   localparam int CLIP_REM_W  = COORD_W + 1 + FRAC_BITS;
   localparam int CLIP_PROD_W = COORD_W + 1 + CLIP_Q_BITS + 1;
   localparam int STEP_W      = CLIP_PROD_W - FRAC_BITS;

   typedef struct packed {
      logic                   vis;
      logic                   clip_a;
      logic                   clip_b;
      point_type              a;
      point_type              b;
      logic [COORD_W-1:0]     den;
      logic [CLIP_REM_W-1:0]  rem;
      logic [CLIP_Q_BITS-1:0] q;
   } cdiv_type;

   typedef struct packed {
      logic                          vis;
      logic                          clip_a;
      logic                          clip_b;
      point_type                     a;
      point_type                     b;
      logic signed [CLIP_PROD_W-1:0] prod_x;
      logic signed [CLIP_PROD_W-1:0] prod_y;
   } cmul_type;

   typedef struct packed {
      logic      vis;
      point_type a;
      point_type b;
   } cout_type;

   // configuration
   logic [SIZE_W-1:0] width_ff, height_ff;
   trig_type          trig_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= WIDTH_RST;
         height_ff     <= HEIGHT_RST;
         trig_ff.cos_z <= TRIG_ONE;
         trig_ff.sin_z <= '0;
         trig_ff.cos_y <= TRIG_ONE;
         trig_ff.sin_y <= '0;
         trig_ff.cos_x <= TRIG_ONE;
         trig_ff.sin_x <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_SCREEN_WIDTH:  width_ff      <= csr_wdata[SIZE_W-1:0];
            CSR_SCREEN_HEIGHT: height_ff     <= csr_wdata[SIZE_W-1:0];
            CSR_COS_ABOUT_Z:   trig_ff.cos_z <= csr_wdata[TRIG_W-1:0];
            CSR_SIN_ABOUT_Z:   trig_ff.sin_z <= csr_wdata[TRIG_W-1:0];
            CSR_COS_ABOUT_Y:   trig_ff.cos_y <= csr_wdata[TRIG_W-1:0];
            CSR_SIN_ABOUT_Y:   trig_ff.sin_y <= csr_wdata[TRIG_W-1:0];
            CSR_COS_ABOUT_X:   trig_ff.cos_x <= csr_wdata[TRIG_W-1:0];
            CSR_SIN_ABOUT_X:   trig_ff.sin_x <= csr_wdata[TRIG_W-1:0];
            default: ;
         endcase
      end
   end

   // flow control
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic                  rsp_valid_ff;
   logic                  en;
   logic                  req_accept;

   assign en           = !vld_ff[PIPE_DEPTH-1] || !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;
   assign req_accept   = req_ch.valid && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_accept};
      end
   end

   // rotation
   point_type a_in, b_in, a_rot, b_rot;

   assign a_in = '{x: req_ch.start_x, y: req_ch.start_y, z: req_ch.start_z};
   assign b_in = '{x: req_ch.end_x,   y: req_ch.end_y,   z: req_ch.end_z};

   srcp_rotator u_rot_a (.clock(clock), .en(en), .pt_in(a_in), .trig(trig_ff), .pt_out(a_rot));
   srcp_rotator u_rot_b (.clock(clock), .en(en), .pt_in(b_in), .trig(trig_ff), .pt_out(b_rot));

   // classify and clip divider setup
   cdiv_type cdiv_ff [0:CLIP_Q_BITS];
   cdiv_type cdiv_in [0:CLIP_Q_BITS];

   always_comb begin
      logic              a_beh, b_beh;
      point_type         p, f;
      logic [COORD_W:0]  gap;
      a_beh = a_rot.z < NEAR_ONE;
      b_beh = b_rot.z < NEAR_ONE;
      p     = a_beh ? a_rot : b_rot;
      f     = a_beh ? b_rot : a_rot;
      gap   = {NEAR_ONE[COORD_W-1], NEAR_ONE} - {p.z[COORD_W-1], p.z};
      cdiv_in[0].vis    = !(a_beh && b_beh);
      cdiv_in[0].clip_a = a_beh && !b_beh;
      cdiv_in[0].clip_b = b_beh && !a_beh;
      cdiv_in[0].a      = a_rot;
      cdiv_in[0].b      = b_rot;
      cdiv_in[0].den    = f.z - p.z;
      cdiv_in[0].rem    = {gap, {FRAC_BITS{1'b0}}};
      cdiv_in[0].q      = '0;
   end

   for (genvar i = 0; i < CLIP_Q_BITS; i++) begin : g_cdiv
      localparam int SH = CLIP_Q_BITS - 1 - i;
      always_comb begin
         logic [CLIP_REM_W-1:0] dsh;
         logic                  ge;
         dsh              = CLIP_REM_W'(cdiv_ff[i].den) << SH;
         ge               = cdiv_ff[i].rem >= dsh;
         cdiv_in[i+1]     = cdiv_ff[i];
         cdiv_in[i+1].rem = ge ? cdiv_ff[i].rem - dsh : cdiv_ff[i].rem;
         cdiv_in[i+1].q   = cdiv_ff[i].q | (CLIP_Q_BITS'(ge) << SH);
      end
   end

   // interpolation product
   cmul_type cmul_ff, cmul_in;

   always_comb begin
      cdiv_type              src;
      point_type             p, f;
      logic signed [COORD_W:0] dx, dy;
      logic signed [CLIP_Q_BITS:0] t;
      src = cdiv_ff[CLIP_Q_BITS];
      p   = src.clip_a ? src.a : src.b;
      f   = src.clip_a ? src.b : src.a;
      dx  = {f.x[COORD_W-1], f.x} - {p.x[COORD_W-1], p.x};
      dy  = {f.y[COORD_W-1], f.y} - {p.y[COORD_W-1], p.y};
      t   = {1'b0, src.q};
      cmul_in.vis    = src.vis;
      cmul_in.clip_a = src.clip_a;
      cmul_in.clip_b = src.clip_b;
      cmul_in.a      = src.a;
      cmul_in.b      = src.b;
      cmul_in.prod_x = CLIP_PROD_W'(dx) * CLIP_PROD_W'(t);
      cmul_in.prod_y = CLIP_PROD_W'(dy) * CLIP_PROD_W'(t);
   end

   // clipped endpoint
   cout_type cout_ff, cout_in;

   always_comb begin
      point_type              p, np;
      logic signed [STEP_W-1:0] sx, sy;
      p    = cmul_ff.clip_a ? cmul_ff.a : cmul_ff.b;
      sx   = {{(STEP_W-COORD_W){p.x[COORD_W-1]}}, p.x}
             + cmul_ff.prod_x[CLIP_PROD_W-1:FRAC_BITS];
      sy   = {{(STEP_W-COORD_W){p.y[COORD_W-1]}}, p.y}
             + cmul_ff.prod_y[CLIP_PROD_W-1:FRAC_BITS];
      np.x = sx[COORD_W-1:0];
      np.y = sy[COORD_W-1:0];
      np.z = NEAR_ONE;
      cout_in.vis = cmul_ff.vis;
      cout_in.a   = cmul_ff.clip_a ? np : cmul_ff.a;
      cout_in.b   = cmul_ff.clip_b ? np : cmul_ff.b;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= CLIP_Q_BITS; k++) begin
            cdiv_ff[k] <= cdiv_in[k];
         end
         cmul_ff <= cmul_in;
         cout_ff <= cout_in;
      end
   end

   // projection
   logic signed [PIX_W-1:0] px0, py0, px1, py1;
   logic [PROJ_STAGES-1:0]  vis_ff;

   srcp_project u_proj_x0 (.clock(clock), .en(en), .coord(cout_ff.a.x), .depth(cout_ff.a.z),
                           .size(width_ff), .pix(px0));
   srcp_project u_proj_y0 (.clock(clock), .en(en), .coord(cout_ff.a.y), .depth(cout_ff.a.z),
                           .size(height_ff), .pix(py0));
   srcp_project u_proj_x1 (.clock(clock), .en(en), .coord(cout_ff.b.x), .depth(cout_ff.b.z),
                           .size(width_ff), .pix(px1));
   srcp_project u_proj_y1 (.clock(clock), .en(en), .coord(cout_ff.b.y), .depth(cout_ff.b.z),
                           .size(height_ff), .pix(py1));

   always_ff @(posedge clock) begin
      if (en) begin
         vis_ff <= {vis_ff[PROJ_STAGES-2:0], cout_ff.vis};
      end
   end

   // output register
   logic                    rsp_vis_ff;
   logic signed [PIX_W-1:0] rsp_x0_ff, rsp_y0_ff, rsp_x1_ff, rsp_y1_ff;
   logic                    load_out;
   logic                    last_vis;

   assign load_out = en && vld_ff[PIPE_DEPTH-1];
   assign last_vis = vis_ff[PROJ_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_vis_ff <= last_vis;
         rsp_x0_ff  <= last_vis ? px0 : '0;
         rsp_y0_ff  <= last_vis ? py0 : '0;
         rsp_x1_ff  <= last_vis ? px1 : '0;
         rsp_y1_ff  <= last_vis ? py1 : '0;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.visible   = rsp_vis_ff;
   assign rsp_ch.screen_x0 = rsp_x0_ff;
   assign rsp_ch.screen_y0 = rsp_y0_ff;
   assign rsp_ch.screen_x1 = rsp_x1_ff;
   assign rsp_ch.screen_y1 = rsp_y1_ff;

   // checks
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> vld_ff[0])
      else $error("accepted word did not enter the pipeline");

   a_freeze_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved while frozen");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(vld_ff[PIPE_DEPTH-1]))
      else $error("response word without a word in the last stage");

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_vis_ff |-> rsp_x0_ff == '0 && rsp_y0_ff == '0
                                      && rsp_x1_ff == '0 && rsp_y1_ff == '0)
      else $error("hidden segment with nonzero coordinates");

endmodule

/* tb/tb_segment_rotate_clip_project.sv */
`timescale 1ns / 1ps
// Self-checking testbench for segment_rotate_clip_project: random and directed segments,
// several camera/screen settings, random sender gaps and receiver stalls.
// Depends on srcp_pkg, srcp_if and the segment_rotate_clip_project RTL.
module tb_segment_rotate_clip_project;
   import srcp_pkg::*;

   typedef struct {
      logic signed [COORD_W-1:0] sx, sy, sz, ex, ey, ez;
   } segment_word_type;

   typedef struct {
      logic                    visible;
      logic signed [PIX_W-1:0] x0, y0, x1, y1;
   } screen_word_type;

   class pixel_scoreboard;
      longint          width, height, cz, sz, cy, sy, cx, sx;
      screen_word_type pending[$];
      int              mismatches;

      function new();
         width = 640; height = 480;
         cz = 16384; sz = 0; cy = 16384; sy = 0; cx = 16384; sx = 0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_SCREEN_WIDTH:  width  = longint'(v[SIZE_W-1:0]);
            CSR_SCREEN_HEIGHT: height = longint'(v[SIZE_W-1:0]);
            CSR_COS_ABOUT_Z:   cz = longint'($signed(v));
            CSR_SIN_ABOUT_Z:   sz = longint'($signed(v));
            CSR_COS_ABOUT_Y:   cy = longint'($signed(v));
            CSR_SIN_ABOUT_Y:   sy = longint'($signed(v));
            CSR_COS_ABOUT_X:   cx = longint'($signed(v));
            CSR_SIN_ABOUT_X:   sx = longint'($signed(v));
            default: ;
         endcase
      endfunction

      function longint scale_sat(longint s);
         longint v;
         v = s >>> TRIG_FRAC_BITS;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         return v;
      endfunction

      function void rotate(inout longint x, inout longint y, inout longint z);
         longint nx, ny, nz;
         nx = scale_sat(x * cz - y * sz);
         ny = scale_sat(x * sz + y * cz);
         x  = scale_sat(nx * cy + z * sy);
         nz = scale_sat(-(nx * sy) + z * cy);
         y  = scale_sat(ny * cx - nz * sx);
         z  = scale_sat(ny * sx + nz * cx);
      endfunction

      function void clip(inout longint ax, inout longint ay, inout longint az,
                         input longint bx, input longint by, input longint bz);
         longint one, t;
         one = 64'sd1 <<< FRAC_BITS;
         t  = ((one - az) <<< FRAC_BITS) / (bz - az);
         ax = ax + (((bx - ax) * t) >>> FRAC_BITS);
         ay = ay + (((by - ay) * t) >>> FRAC_BITS);
         az = one;
      endfunction

      function logic signed [PIX_W-1:0] to_pixel(longint c, longint z, longint size);
         longint n, d, q;
         n = size * (c + z);
         d = 2 * z;
         q = n / d;
         if ((n % d) != 0 && n < 0) q = q - 1;
         if (q < -32768) q = -32768;
         if (q > 32767) q = 32767;
         return q[PIX_W-1:0];
      endfunction

      function void note(segment_word_type s);
         longint          ax, ay, az, bx, by, bz, one;
         screen_word_type r;
         one = 64'sd1 <<< FRAC_BITS;
         ax = s.sx; ay = s.sy; az = s.sz;
         bx = s.ex; by = s.ey; bz = s.ez;
         rotate(ax, ay, az);
         rotate(bx, by, bz);
         r = '{visible: 1'b0, x0: '0, y0: '0, x1: '0, y1: '0};
         if (!(az < one && bz < one)) begin
            if (az < one) clip(ax, ay, az, bx, by, bz);
            else if (bz < one) clip(bx, by, bz, ax, ay, az);
            r.visible = 1'b1;
            r.x0 = to_pixel(ax, az, width);
            r.y0 = to_pixel(ay, az, height);
            r.x1 = to_pixel(bx, bz, width);
            r.y1 = to_pixel(by, bz, height);
         end
         pending.push_back(r);
      endfunction

      function void check(screen_word_type got);
         screen_word_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: vis=%0b %0d %0d %0d %0d",
                                           got.visible, got.x0, got.y0, got.x1, got.y1);
            return;
         end
         want = pending.pop_front();
         if (got.visible !== want.visible || got.x0 !== want.x0 || got.y0 !== want.y0 ||
             got.x1 !== want.x1 || got.y1 !== want.y1) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp vis=%0b %0d %0d %0d %0d, got vis=%0b %0d %0d %0d %0d",
                        want.visible, want.x0, want.y0, want.x1, want.y1,
                        got.visible, got.x0, got.y0, got.x1, got.y1);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   srcp_req_if req_ch();
   srcp_rsp_if rsp_ch();

   segment_rotate_clip_project uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   pixel_scoreboard sb = new();
   int burst_left = 0;
   int stall_mode = 0;
   int stall_cnt  = 0;

   localparam logic signed [COORD_W-1:0] ONE  = 32'sd65536;
   localparam logic signed [COORD_W-1:0] CMAX = 32'sh7FFFFFFF;
   localparam logic signed [COORD_W-1:0] CMIN = 32'sh80000000;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   initial begin
      #10ms;
      $display("tb: failure");
      $finish;
   end

   // receiver stall pattern; a stall counter picks among four random modes
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         stall_cnt <= stall_cnt + 1;
         if (stall_cnt % 300 == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= (stall_cnt[3:0] < 5);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check('{visible: rsp_ch.visible, x0: rsp_ch.screen_x0, y0: rsp_ch.screen_y0,
                    x1: rsp_ch.screen_x1, y1: rsp_ch.screen_y1});
   end

   task automatic csr_write(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      sb.set_reg(idx, v);
      @(posedge clock);
   endtask

   task automatic configure(logic [15:0] w, logic [15:0] h, logic [15:0] czv,
                            logic [15:0] szv, logic [15:0] cyv, logic [15:0] syv,
                            logic [15:0] cxv, logic [15:0] sxv);
      csr_write(CSR_SCREEN_WIDTH, w);
      csr_write(CSR_SCREEN_HEIGHT, h);
      csr_write(CSR_COS_ABOUT_Z, czv);
      csr_write(CSR_SIN_ABOUT_Z, szv);
      csr_write(CSR_COS_ABOUT_Y, cyv);
      csr_write(CSR_SIN_ABOUT_Y, syv);
      csr_write(CSR_COS_ABOUT_X, cxv);
      csr_write(CSR_SIN_ABOUT_X, sxv);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // sender: random bursts with random gaps
   task automatic send(segment_word_type s);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 30);
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.start_x <= s.sx;
      req_ch.start_y <= s.sy;
      req_ch.start_z <= s.sz;
      req_ch.end_x   <= s.ex;
      req_ch.end_y   <= s.ey;
      req_ch.end_z   <= s.ez;
      do @(posedge clock); while (!req_ch.ready);
      sb.note(s);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   function automatic logic signed [COORD_W-1:0] rnd_coord(int mode, bit depth);
      case (mode)
         0: return depth ? int'($urandom_range(0, 40 * 65536)) - 8 * 65536
                         : int'($urandom_range(0, 400 * 65536)) - 200 * 65536;
         1: return depth ? ONE + int'($urandom_range(0, 4096)) - 2048
                         : int'($urandom_range(0, 2 * 65536)) - 65536;
         default: return $urandom;
      endcase
   endfunction

   function automatic segment_word_type rnd_segment();
      segment_word_type s;
      int               mode;
      mode = $urandom_range(0, 9);
      mode = (mode < 6) ? 0 : (mode < 8 ? 1 : 2);
      s.sx = rnd_coord(mode, 0);
      s.sy = rnd_coord(mode, 0);
      s.sz = rnd_coord(mode, 1);
      s.ex = rnd_coord(mode, 0);
      s.ey = rnd_coord(mode, 0);
      s.ez = rnd_coord(mode, 1);
      return s;
   endfunction

   task automatic send_random(int n);
      repeat (n) send(rnd_segment());
   endtask

   task automatic send_directed();
      segment_word_type d[$];
      d.push_back('{0, 0, 0, 0, 0, 0});
      d.push_back('{0, 0, ONE, 0, 0, ONE});
      d.push_back('{ONE, -ONE, 2 * ONE, -ONE, ONE, 4 * ONE});
      d.push_back('{ONE, ONE, ONE - 1, ONE, ONE, ONE - 1});
      d.push_back('{ONE, ONE, -8 * ONE, -ONE, ONE, 3 * ONE});
      d.push_back('{ONE, 2 * ONE, 5 * ONE, -ONE, -ONE, -5 * ONE});
      d.push_back('{3 * ONE, 0, -ONE, 0, 3 * ONE, ONE});
      d.push_back('{0, 0, ONE, 5 * ONE, 5 * ONE, ONE - 1});
      d.push_back('{CMAX, CMAX, CMAX, CMIN, CMIN, CMAX});
      d.push_back('{CMIN, CMIN, CMIN, CMAX, CMAX, CMIN});
      d.push_back('{CMAX, CMIN, ONE, CMIN, CMAX, ONE});
      d.push_back('{CMAX, CMAX, CMIN, CMIN, CMIN, CMAX});
      d.push_back('{CMIN, CMAX, CMAX, CMAX, CMIN, CMIN});
      d.push_back('{-1, -1, -1, -1, -1, -1});
      d.push_back('{100 * ONE, -100 * ONE, ONE, 0, 0, 1000 * ONE});
      d.push_back('{1, 1, ONE, -1, -1, ONE});
      foreach (d[i]) send(d[i]);
   endtask

   task automatic random_trig();
      configure(16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096)),
                16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384),
                16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384),
                16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384));
   endtask

   initial begin
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_addr     = '0;
      csr_wdata    = '0;
      req_ch.valid = 1'b0;
      req_ch.start_x = '0; req_ch.start_y = '0; req_ch.start_z = '0;
      req_ch.end_x   = '0; req_ch.end_y   = '0; req_ch.end_z   = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_directed();
      send_random(120);
      drain();
      send_random(130);
      drain();

      configure(16'd1, 16'd1, 16'd16384, 16'd0, 16'd16384, 16'd0, 16'd16384, 16'd0);
      send_directed();
      send_random(200);
      drain();

      configure(16'd4096, 16'd4096, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384,
                -16'sd16384, -16'sd16384);
      send_directed();
      send_random(200);
      drain();

      configure(16'd0, 16'h1FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                16'h7FFF, 16'h8000);
      send_directed();
      send_random(200);
      drain();

      configure(16'hFFFF, 16'd4096, 16'd0, 16'd16384, 16'd0, -16'sd16384,
                16'd11585, 16'd11585);
      send_random(200);
      drain();

      repeat (4) begin
         random_trig();
         send_random(175);
         drain();
      end

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

/* filelist.f */
design/srcp_pkg.sv
design/srcp_if.sv
design/srcp_rotator.sv
design/srcp_project.sv
design/segment_rotate_clip_project.sv
tb/tb_segment_rotate_clip_project.sv
